// ===== hdl/ksa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ksa_pkg
// Shared types and constants for the key scanner with accelerating auto-repeat.
// -----------------------------------------------------------------------------
package ksa_pkg;

  localparam int unsigned KeyW   = 4;
  localparam int unsigned SpeedW = 3;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWAP_OUTER = 3'd0,
    CFG_THR_SLOW   = 3'd1,
    CFG_THR_TEN    = 3'd2,
    CFG_THR_FIFTY  = 3'd3,
    CFG_THR_FAST   = 3'd4
  } cfg_idx_e;

  localparam logic [SpeedW-1:0] SpeedChange = 3'd0;
  localparam logic [SpeedW-1:0] SpeedOne    = 3'd1;
  localparam logic [SpeedW-1:0] SpeedTwo    = 3'd2;
  localparam logic [SpeedW-1:0] SpeedThree  = 3'd3;
  localparam logic [SpeedW-1:0] SpeedFour   = 3'd4;

  localparam logic [CountW-1:0] ThrSlowRst  = 8'd5;
  localparam logic [CountW-1:0] ThrTenRst   = 8'd20;
  localparam logic [CountW-1:0] ThrFiftyRst = 8'd40;
  localparam logic [CountW-1:0] ThrFastRst  = 8'd60;

  typedef struct packed {
    logic              swap_outer;
    logic [CountW-1:0] thr_slow;
    logic [CountW-1:0] thr_ten;
    logic [CountW-1:0] thr_fifty;
    logic [CountW-1:0] thr_fast;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic [KeyW-1:0]   keys;
    logic [SpeedW-1:0] speed;
  } result_t;

endpackage : ksa_pkg
`default_nettype wire

// ===== hdl/ksa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ksa_if
// Valid/ready channels: key sample requests, key events and register writes.
// -----------------------------------------------------------------------------
interface ksa_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] first_sample;
  logic [3:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface : ksa_in_if

interface ksa_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pressed_keys;
  logic [2:0] speed_level;

  modport source (output valid, output pressed_keys, output speed_level, input ready);
  modport sink   (input valid, input pressed_keys, input speed_level, output ready);
endinterface : ksa_out_if

interface ksa_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : ksa_cfg_if
`default_nettype wire

// ===== hdl/ksa_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ksa_cfg_regs
// Configuration register file: swap mode and the four repeat thresholds.
// -----------------------------------------------------------------------------
module ksa_cfg_regs
  import ksa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_SWAP_OUTER: cfg_d.swap_outer = wr_data_i[0];
        CFG_THR_SLOW:   cfg_d.thr_slow   = wr_data_i;
        CFG_THR_TEN:    cfg_d.thr_ten    = wr_data_i;
        CFG_THR_FIFTY:  cfg_d.thr_fifty  = wr_data_i;
        CFG_THR_FAST:   cfg_d.thr_fast   = wr_data_i;
        default:        cfg_d = cfg_q; // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swap_outer <= 1'b0;
      cfg_q.thr_slow   <= ThrSlowRst;
      cfg_q.thr_ten    <= ThrTenRst;
      cfg_q.thr_fifty  <= ThrFiftyRst;
      cfg_q.thr_fast   <= ThrFastRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : ksa_cfg_regs
`default_nettype wire

// ===== hdl/ksa_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ksa_step
// Per-tick evaluation: debounce, swap, change detect, repeat speed, next state.
// -----------------------------------------------------------------------------
module ksa_step
  import ksa_pkg::*;
(
  input  cfg_t                    cfg_i,
  input  wire logic [KeyW-1:0]    first_i,
  input  wire logic [KeyW-1:0]    second_i,
  input  wire logic [KeyW-1:0]    last_keys_i,
  input  wire logic [CountW-1:0]  hold_i,
  output result_t                 res_o,
  output logic [KeyW-1:0]         last_keys_o,
  output logic [CountW-1:0]       hold_o
);

  logic [KeyW-1:0]   down;
  logic [KeyW-1:0]   keys;
  logic [SpeedW-1:0] level;
  logic              reach_slow;

  always_comb begin
    down = ~first_i & ~second_i;
    keys = down;
    if (cfg_i.swap_outer) begin
      keys = {down[3], down[0], down[1], down[2]};
    end

    reach_slow = (hold_i >= cfg_i.thr_slow);
    if (hold_i >= cfg_i.thr_fast) begin
      level = SpeedFour;
    end else if (hold_i >= cfg_i.thr_fifty) begin
      level = SpeedThree;
    end else if (hold_i >= cfg_i.thr_ten) begin
      level = SpeedTwo;
    end else if (reach_slow) begin
      level = SpeedOne;
    end else begin
      level = SpeedChange;
    end

    res_o.keys  = keys;
    res_o.speed = SpeedChange;
    res_o.emit  = 1'b0;
    last_keys_o = last_keys_i;
    hold_o      = hold_i;

    if (keys != last_keys_i) begin
      res_o.emit  = 1'b1;
      last_keys_o = keys;
      hold_o      = '0;
    end else if (keys != '0) begin
      res_o.emit  = reach_slow;
      res_o.speed = level;
      // saturate at the fast threshold
      if (hold_i < cfg_i.thr_fast) begin
        hold_o = hold_i + CountW'(1);
      end
    end
  end

endmodule : ksa_step
`default_nettype wire

// ===== hdl/ksa_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ksa_pipe
// Sample register, scan state and event output register around ksa_step.
// -----------------------------------------------------------------------------
module ksa_pipe
  import ksa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_t                   cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KeyW-1:0]   first_i,
  input  wire logic [KeyW-1:0]   second_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KeyW-1:0]        keys_o,
  output logic [SpeedW-1:0]      speed_o
);

  logic                in_valid_q, in_valid_d;
  logic [KeyW-1:0]     first_q, second_q;
  logic [KeyW-1:0]     last_keys_q, last_keys_d;
  logic [CountW-1:0]   hold_q, hold_d;
  logic                out_valid_q, out_valid_d;
  logic [KeyW-1:0]     out_keys_q;
  logic [SpeedW-1:0]   out_speed_q;
  result_t             res;
  logic                advance;
  logic                in_take;
  logic                out_free;

  ksa_step u_step (
    .cfg_i       (cfg_i),
    .first_i     (first_q),
    .second_i    (second_q),
    .last_keys_i (last_keys_q),
    .hold_i      (hold_q),
    .res_o       (res),
    .last_keys_o (last_keys_d),
    .hold_o      (hold_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  // retire the held request unless its event has nowhere to go
  assign advance    = in_valid_q && (!res.emit || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) in_valid_d = 1'b0;
    if (in_take) in_valid_d = 1'b1;

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (advance && res.emit)        out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_keys_q <= '0;
      hold_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        last_keys_q <= last_keys_d;
        hold_q      <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      first_q  <= first_i;
      second_q <= second_i;
    end
    if (advance && res.emit) begin
      out_keys_q  <= res.keys;
      out_speed_q <= res.speed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign keys_o      = out_keys_q;
  assign speed_o     = out_speed_q;

endmodule : ksa_pipe
`default_nettype wire

// ===== hdl/key_scan_autorepeat_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// key_scan_autorepeat_top
// Key scanner with debounce, outer key swap and accelerating auto-repeat.
//
// Channels: in_i carries one scan tick (two active-low samples of four keys),
// out_o delivers key events (pressed mask and speed level 0..4), cfg_i writes
// the swap mode (index 0) and thresholds slow/ten/fifty/fast (indexes 1..4).
// Register writes are always taken; unmapped indexes are dropped.
// Path: a request is held in the sample register, evaluated, and its event is
// then registered in the event register, from which it is valid on out_o.
// Throughput: one request per cycle while out_o is not stalled; the sample
// register and the event register are separate, so one request is still
// taken while an event waits. Ticks that cause no event (idle or below the
// slow threshold) retire without using the output register.
// Reset: no key pressed, hold count zero, thresholds 5/20/40/60, swap off,
// both channels empty.
// Stall: while out_o is held off, a request that causes an event waits in the
// sample register and in_i.ready drops until the waiting event is taken.
// -----------------------------------------------------------------------------
module key_scan_autorepeat_top
  import ksa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ksa_in_if.sink     in_i,
  ksa_out_if.source  out_o,
  ksa_cfg_if.sink    cfg_i
);

  cfg_t cfg;

  assign cfg_i.ready = 1'b1;

  ksa_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  ksa_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .first_i     (in_i.first_sample),
    .second_i    (in_i.second_sample),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .keys_o      (out_o.pressed_keys),
    .speed_o     (out_o.speed_level)
  );

endmodule : key_scan_autorepeat_top
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key scanner with debounce and accelerating
// auto-repeat. Scan requests go in over the sample channel. A predictor inside
// the bench tracks the debounced key set, the hold count and the register
// settings, and queues the key event that each request should cause. Each
// event taken from the output channel is checked against the oldest queued
// one. The bench runs directed cases, then random hold sequences under
// several register settings, and ends with a back-pressure case. Random
// gaps and stalls are applied on both channels.
// -----------------------------------------------------------------------------
module testbench;
  import ksa_pkg::*;

  localparam int CfgIdxUnmapped = int'(CFG_THR_FAST) + 1;
  localparam int CfgIdxCount    = 1 << CfgIdxW;
  localparam int RxHoldCycles   = 80;
  localparam int SettleCycles   = 4;
  localparam int RandomPhases   = 5;
  localparam int ItemsPerPhase  = 60;

  typedef struct packed {
    logic [KeyW-1:0]   keys;
    logic [SpeedW-1:0] speed;
  } key_event_t;

  logic clk_i;
  logic rst_ni;

  ksa_in_if  in_if ();
  ksa_out_if out_if ();
  ksa_cfg_if cfg_if ();

  key_scan_autorepeat_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state
  cfg_t              model_cfg;
  logic [KeyW-1:0]   held_keys;
  logic [CountW-1:0] hold_ticks;
  key_event_t        key_event_q[$];

  int err_count;
  bit tx_gaps_en;
  bit rx_stall_en;
  bit rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void predict_key_event(input logic [KeyW-1:0] first_s,
                                            input logic [KeyW-1:0] second_s,
                                            output logic emit,
                                            output key_event_t ev);
    logic [KeyW-1:0]   down;
    logic [SpeedW-1:0] lvl;
    down = ~first_s & ~second_s;
    if (model_cfg.swap_outer) begin
      down = {down[3], down[0], down[1], down[2]};
    end
    emit     = 1'b0;
    ev.keys  = down;
    ev.speed = SpeedChange;
    if (down != held_keys) begin
      emit       = 1'b1;
      held_keys  = down;
      hold_ticks = '0;
    end else if (down != '0) begin
      // highest threshold reached wins; emission gated by the slow one alone
      if (hold_ticks >= model_cfg.thr_fast) lvl = SpeedFour;
      else if (hold_ticks >= model_cfg.thr_fifty) lvl = SpeedThree;
      else if (hold_ticks >= model_cfg.thr_ten) lvl = SpeedTwo;
      else if (hold_ticks >= model_cfg.thr_slow) lvl = SpeedOne;
      else lvl = SpeedChange;
      if (hold_ticks >= model_cfg.thr_slow) begin
        emit     = 1'b1;
        ev.speed = lvl;
      end
      if (hold_ticks < model_cfg.thr_fast) hold_ticks = hold_ticks + 1'b1;
    end
  endfunction

  // Send one scan request and queue the event it should cause
  task automatic send_scan(input logic [KeyW-1:0] first_s, input logic [KeyW-1:0] second_s);
    int         gap;
    logic       emit;
    key_event_t ev;
    gap = tx_gaps_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.first_sample  <= first_s;
    in_if.second_sample <= second_s;
    do @(posedge clk_i); while (!in_if.ready);
    predict_key_event(first_s, second_s, emit, ev);
    if (emit) key_event_q.push_back(ev);
  endtask

  // Send a tick holding the given debounced set, with bounce on released lines
  task automatic send_held(input logic [KeyW-1:0] keys);
    logic [KeyW-1:0] other;
    logic [KeyW-1:0] m;
    logic [KeyW-1:0] n;
    other = ~keys;
    m     = KeyW'($urandom);
    n     = KeyW'($urandom);
    send_scan(other & m, other & (~m | n));
  endtask

  // Drop the request line and wait until every queued event has been taken
  task automatic settle();
    in_if.valid <= 1'b0;
    while (key_event_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_SWAP_OUTER: model_cfg.swap_outer = data[0];
      CFG_THR_SLOW:   model_cfg.thr_slow   = data;
      CFG_THR_TEN:    model_cfg.thr_ten    = data;
      CFG_THR_FIFTY:  model_cfg.thr_fifty  = data;
      CFG_THR_FAST:   model_cfg.thr_fast   = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic swap, input logic [CountW-1:0] slow,
                                input logic [CountW-1:0] ten, input logic [CountW-1:0] fifty,
                                input logic [CountW-1:0] fast);
    settle();
    // junk in the upper bits of the swap write must be ignored
    write_reg(CFG_SWAP_OUTER, {7'($urandom), swap});
    write_reg(CFG_THR_SLOW, slow);
    write_reg(CFG_THR_TEN, ten);
    write_reg(CFG_THR_FIFTY, fifty);
    write_reg(CFG_THR_FAST, fast);
  endtask

  task automatic test_reset_defaults();
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
    send_scan(4'hF, 4'hF);             // idle, no event
    send_scan(4'h0, 4'hF);             // low on one read only: not pressed
    send_scan(4'h5, 4'hA);
    send_scan(4'hE, 4'hE);             // key one down
    repeat (6) send_scan(4'hE, 4'hE);  // first repeat at the slow threshold
    send_scan(4'hE, 4'hF);             // bounce reads as release
    send_scan(4'h0, 4'h0);             // every key
    repeat (2) send_scan(4'h0, 4'h0);
    send_scan(4'hF, 4'hF);             // release
  endtask

  task automatic test_speed_levels();
    set_thresholds(1'b1, 8'd1, 8'd2, 8'd3, 8'd4);
    send_scan(4'hE, 4'hE);             // key one lands on bit two
    repeat (6) send_scan(4'hE, 4'hE);  // climb to level four and saturate
    send_scan(4'hB, 4'hB);
    send_scan(4'hA, 4'hA);
    repeat (2) send_scan(4'hA, 4'hA);
    send_scan(4'hF, 4'hF);
    repeat (2) send_scan(4'hF, 4'hF);  // idle held: nothing
  endtask

  task automatic test_threshold_corners();
    // slow above fast: no repeat ever
    set_thresholds(1'b0, 8'd200, 8'd10, 8'd10, 8'd3);
    repeat (8) send_scan(4'h7, 4'h7);
    // let the count run up, then lower every threshold below it
    set_thresholds(1'b0, 8'd2, 8'd255, 8'd255, 8'd255);
    repeat (11) send_scan(4'h6, 4'h6);
    set_thresholds(1'b0, 8'd1, 8'd2, 8'd3, 8'd4);
    repeat (2) send_scan(4'h6, 4'h6);
    // all zero: count pinned at zero, every held tick repeats at level four
    set_thresholds(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
    send_scan(4'h3, 4'h3);
    repeat (3) send_scan(4'h3, 4'h3);
    set_thresholds(1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_scan(4'hC, 4'hC);
    repeat (3) send_scan(4'hC, 4'hC);
    settle();
    write_reg(CFG_SWAP_OUTER, 8'hFE);  // bit zero clear: swap off
    for (int i = CfgIdxUnmapped; i < CfgIdxCount; i++) begin
      write_reg(CfgIdxW'(i), 8'h00);   // unmapped: dropped
    end
    send_scan(4'hE, 4'hE);
    repeat (3) send_scan(4'hE, 4'hE);
  endtask

  task automatic test_random_holds();
    int               n;
    int               r;
    int               len;
    int               lim;
    logic [KeyW-1:0]  keys;
    logic [CountW-1:0] slow;
    logic [CountW-1:0] ten;
    logic [CountW-1:0] fifty;
    logic [CountW-1:0] fast;
    for (int p = 0; p < RandomPhases; p++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        slow  = CountW'($urandom_range(0, 5));
        ten   = slow + CountW'($urandom_range(0, 5));
        fifty = ten + CountW'($urandom_range(0, 5));
        fast  = fifty + CountW'($urandom_range(0, 5));
      end else if (r < 9) begin
        slow  = CountW'($urandom);
        ten   = CountW'($urandom);
        fifty = CountW'($urandom);
        fast  = CountW'($urandom);
      end else begin
        slow  = ThrSlowRst;
        ten   = ThrTenRst;
        fifty = ThrFiftyRst;
        fast  = ThrFastRst;
      end
      set_thresholds(1'($urandom), slow, ten, fifty, fast);
      // first phase runs flat out on both sides
      tx_gaps_en  = (p != 0);
      rx_stall_en = (p != 0);
      lim = (int'(fast) + 3 > 30) ? 30 : int'(fast) + 3;
      n = 0;
      while (n < ItemsPerPhase) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_scan(KeyW'($urandom), KeyW'($urandom));
          n++;
        end else begin
          keys = (r < 22) ? '0 : KeyW'($urandom_range(1, 15));
          len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, lim);
          for (int j = 0; j < len && n < ItemsPerPhase; j++) begin
            send_held(keys);
            n++;
            // break the hold now and then
            if ($urandom_range(0, 39) == 0) begin
              send_scan(KeyW'($urandom), KeyW'($urandom));
              n++;
            end
          end
        end
      end
    end
  endtask

  task automatic test_backpressure();
    logic [KeyW-1:0] s;
    set_thresholds(1'b0, ThrSlowRst, ThrTenRst, ThrFiftyRst, ThrFastRst);
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    rx_hold_req = 1'b1;
    s = 4'hF;
    // every request changes the key set, so each one fills an event slot
    for (int i = 0; i < 24; i++) begin
      s = s ^ KeyW'($urandom_range(1, 15));
      send_scan(s, s);
    end
    settle();
    rx_stall_en = 1'b1;
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : event_check
    key_event_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (key_event_q.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual keys=%h speed=%0d",
                 $time, out_if.pressed_keys, out_if.speed_level);
        err_count++;
      end else begin
        want = key_event_q.pop_front();
        if (out_if.pressed_keys !== want.keys) begin
          $display("%0t: pressed_keys mismatch: expected %h, actual %h",
                   $time, want.keys, out_if.pressed_keys);
          err_count++;
        end
        if (out_if.speed_level !== want.speed) begin
          $display("%0t: speed_level mismatch: expected %0d, actual %0d",
                   $time, want.speed, out_if.speed_level);
          err_count++;
        end
      end
    end
  end

  initial begin
    err_count   = 0;
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    rx_hold_req = 1'b0;
    model_cfg   = '{swap_outer: 1'b0, thr_slow: ThrSlowRst, thr_ten: ThrTenRst,
                    thr_fifty: ThrFiftyRst, thr_fast: ThrFastRst};
    held_keys   = '0;
    hold_ticks  = '0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.first_sample  = 4'hF;
    in_if.second_sample = 4'hF;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_speed_levels();
    test_threshold_corners();
    test_random_holds();
    test_backpressure();

    settle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : testbench

// ===== sim.f =====
hdl/ksa_pkg.sv
hdl/ksa_if.sv
hdl/ksa_cfg_regs.sv
hdl/ksa_step.sv
hdl/ksa_pipe.sv
hdl/key_scan_autorepeat_top.sv
dv/testbench.sv
